>>> sv/approx_log_multiplier_soa_defines.svh
// Assertion macros shared by the approximate log multiplier RTL.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef APPROX_LOG_MULTIPLIER_SOA_DEFINES_SVH
`define APPROX_LOG_MULTIPLIER_SOA_DEFINES_SVH
`ifndef SYNTHESIS
`define ALM_ASSERT_SAME(lbl, cond_a, cond_b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_b)) \
      else $error("same-cycle check failed");
`define ALM_ASSERT_NEXT(lbl, cond_a, cond_b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond_a) |=> (cond_b)) \
      else $error("next-cycle check failed");
`else
`define ALM_ASSERT_SAME(lbl, cond_a, cond_b)
`define ALM_ASSERT_NEXT(lbl, cond_a, cond_b)
`endif
`endif

>>> sv/alm_pkg.sv
package alm_pkg;

   localparam int OPERAND_BITS = 8;
   localparam int FRAC_BITS    = OPERAND_BITS - 1;
   localparam int IN_BITS      = 9;
   localparam int PRODUCT_BITS = 16;
   localparam int TRUNC_BITS   = 3;
   localparam int K_BITS       = $clog2(OPERAND_BITS);
   localparam int KL_BITS      = $clog2(2 * (OPERAND_BITS - 1) + 2);
   localparam int SHIFT_BITS   = 3 * OPERAND_BITS - 1;

   localparam logic [TRUNC_BITS-1:0] TRUNC_RESET = TRUNC_BITS'(3);

   // Normalized operand pair after the first stage.
   typedef struct packed {
      logic                  zero;
      logic [K_BITS-1:0]     ka;
      logic [K_BITS-1:0]     kb;
      logic [FRAC_BITS-1:0]  ya;
      logic [FRAC_BITS-1:0]  yb;
      logic [TRUNC_BITS-1:0] w;
   } norm_type;

   // Log-domain sum after the second stage.
   typedef struct packed {
      logic                 zero;
      logic [KL_BITS-1:0]   kl;
      logic [FRAC_BITS-1:0] frac;
   } logsum_type;

endpackage

>>> sv/alm_norm.sv
module alm_norm (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic signed [alm_pkg::IN_BITS-1:0]  operand_a,
   input  logic signed [alm_pkg::IN_BITS-1:0]  operand_b,
   input  logic [alm_pkg::TRUNC_BITS-1:0]      trunc_width,
   output logic                                out_valid,
   output alm_pkg::norm_type                   out_data
);
   import alm_pkg::*;

   // Magnitude of a two's complement word, kept modulo 2^OPERAND_BITS.
   function automatic logic [OPERAND_BITS-1:0] magnitude(input logic [IN_BITS-1:0] v);
      logic [IN_BITS-1:0] m;
      m = v[IN_BITS-1] ? (~v + IN_BITS'(1)) : v;
      return m[OPERAND_BITS-1:0];
   endfunction

   // Position of the highest set bit.
   function automatic logic [K_BITS-1:0] lead_one(input logic [OPERAND_BITS-1:0] v);
      logic [K_BITS-1:0] pos;
      pos = '0;
      for (int i = 0; i < OPERAND_BITS; i++) begin
         if (v[i]) begin
            pos = K_BITS'(i);
         end
      end
      return pos;
   endfunction

   logic [OPERAND_BITS-1:0] mag_a, mag_b;
   logic                    valid_ff, valid_in;
   norm_type                data_ff, data_in;

   always_comb begin
      mag_a = magnitude(operand_a);
      mag_b = magnitude(operand_b);
      data_in.zero = (mag_a == '0) || (mag_b == '0);
      data_in.ka   = lead_one(mag_a);
      data_in.kb   = lead_one(mag_b);
      data_in.ya   = FRAC_BITS'(mag_a << (K_BITS'(FRAC_BITS) - data_in.ka));
      data_in.yb   = FRAC_BITS'(mag_b << (K_BITS'(FRAC_BITS) - data_in.kb));
      data_in.w    = (trunc_width > TRUNC_BITS'(FRAC_BITS)) ?
                     TRUNC_BITS'(FRAC_BITS) : trunc_width;
      valid_in     = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> sv/alm_fadd.sv
module alm_fadd (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  alm_pkg::norm_type   in_data,
   output logic                out_valid,
   output alm_pkg::logsum_type out_data
);
   import alm_pkg::*;

   localparam logic [FRAC_BITS-1:0] FRAC_ONES = '1;

   logic [FRAC_BITS-1:0] ones, keep, both_shift;
   logic [FRAC_BITS:0]   carry, sum;
   logic                 valid_ff, valid_in;
   logsum_type           data_ff, data_in;

   always_comb begin
      ones       = ~(FRAC_ONES << in_data.w);
      keep       = ~ones;
      both_shift = (in_data.ya & in_data.yb) >> (in_data.w - TRUNC_BITS'(1));
      carry      = ((in_data.w != '0) && both_shift[0]) ?
                   ((FRAC_BITS+1)'(1) << in_data.w) : '0;
      sum        = ({1'b0, in_data.ya & keep} + {1'b0, in_data.yb & keep} + carry)
                   | {1'b0, ones};
      data_in.zero = in_data.zero;
      data_in.kl   = KL_BITS'(in_data.ka) + KL_BITS'(in_data.kb)
                     + KL_BITS'(sum[FRAC_BITS]);
      data_in.frac = sum[FRAC_BITS-1:0];
      valid_in     = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> sv/alm_antilog.sv
module alm_antilog (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  alm_pkg::logsum_type               in_data,
   output logic                              out_valid,
   output logic [alm_pkg::PRODUCT_BITS-1:0]  out_product
);
   import alm_pkg::*;

   logic [SHIFT_BITS-1:0]   wide;
   logic [PRODUCT_BITS-1:0] product_ff, product_in;
   logic                    valid_ff, valid_in;

   always_comb begin
      // The hidden one is restored before the mantissa is scaled by 2^kl.
      wide       = SHIFT_BITS'({1'b1, in_data.frac}) << in_data.kl;
      product_in = in_data.zero ? '0 : PRODUCT_BITS'(wide >> FRAC_BITS);
      valid_in   = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         product_ff <= product_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_product = product_ff;

endmodule

>>> sv/approx_log_multiplier_soa.sv
// Approximate multiplier for error-tolerant streams: each word carries two
// signed 9-bit operands and returns the unsigned 16-bit magnitude of their
// product, computed in the log domain with a Mitchell approximation and a
// set-one adder. The operand magnitudes are taken modulo 256, so a zero or
// -256 operand yields zero. The low trunc_width fraction bits (reset 3)
// are dropped and forced to one, which trades accuracy for a shorter adder.
// The pipeline has three register stages: normalization with leading-one
// detection, the fraction add, and the antilog shift. A word is accepted
// every cycle while the result channel is not stalled, and each result passes
// through the normalization, add and antilog registers in turn. A stall on the result side holds
// the whole pipeline in place. trunc_width is to be written only while no
// words are in flight; csr_ready is always high.
module approx_log_multiplier_soa (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [alm_pkg::IN_BITS-1:0]  req_operand_a,
   input  logic signed [alm_pkg::IN_BITS-1:0]  req_operand_b,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [alm_pkg::PRODUCT_BITS-1:0]    rsp_product_mag,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [alm_pkg::TRUNC_BITS-1:0]      csr_trunc_width
);
   import alm_pkg::*;

`include "approx_log_multiplier_soa_defines.svh"

   logic [TRUNC_BITS-1:0] trunc_width_ff, trunc_width_in;
   logic                  advance;
   logic                  s1_valid, s2_valid;
   norm_type              s1_data;
   logsum_type            s2_data;

   // The pipeline moves whenever the output register is empty or being
   // drained, so a full pipeline with a ready consumer takes a word each cycle.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_comb begin
      trunc_width_in = (csr_valid && csr_ready) ? csr_trunc_width : trunc_width_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trunc_width_ff <= TRUNC_RESET;
      end else begin
         trunc_width_ff <= trunc_width_in;
      end
   end

   alm_norm u_norm (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .operand_a   (req_operand_a),
      .operand_b   (req_operand_b),
      .trunc_width (trunc_width_ff),
      .out_valid   (s1_valid),
      .out_data    (s1_data)
   );

   alm_fadd u_fadd (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   alm_antilog u_antilog (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s2_valid),
      .in_data     (s2_data),
      .out_valid   (rsp_valid),
      .out_product (rsp_product_mag)
   );

   // A word in the first stage reaches the second when the pipeline moves.
   `ALM_ASSERT_NEXT(a_s1_to_s2, advance && s1_valid, s2_valid)
   // A stalled pipeline keeps its occupancy.
   `ALM_ASSERT_NEXT(a_stall_holds, !advance, $stable(s1_valid) && $stable(s2_valid))
   // A zero operand always produces a zero word.
   `ALM_ASSERT_NEXT(a_zero_result, advance && s2_valid && s2_data.zero,
                    rsp_valid && (rsp_product_mag == '0))
   // With nonzero operands the hidden one makes the product at least one.
   `ALM_ASSERT_NEXT(a_nonzero_result, advance && s2_valid && !s2_data.zero,
                    rsp_valid && (rsp_product_mag != '0))

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the approximate log-domain multiplier. Operand words go in
// on the req_ channel, product magnitudes come back on the rsp_ channel, and
// the truncation width is set through the csr_ port. Every accepted operand
// word produces one product word. The product is worked out here from the
// operands and the truncation width that was in force when the word was
// accepted. It is then queued and compared with the next product word that
// the block hands back.
module tb_top;
   import alm_pkg::*;

   localparam int RESET_CYCLES    = 10;
   localparam int PHASE_COUNT     = 8;
   localparam int WORDS_PER_PHASE = 210;
   // The pipeline has three stages; this slack is waited out after the last
   // product word to see whether any stray product word still comes out.
   localparam int DRAIN_SLACK     = 8;
   localparam int HOLD_CYCLES     = 80;
   localparam int CYCLE_LIMIT     = 200000;

   typedef logic signed [IN_BITS-1:0] operand_type;
   typedef logic [PRODUCT_BITS-1:0]   product_type;

   // One row of the directed stimulus. When has_product is set, the product
   // is typed in by hand. Otherwise it comes from the predictor.
   typedef struct {
      operand_type a;
      operand_type b;
      bit          has_product;
      product_type product;
   } directed_row_type;

   // The directed rows run at the reset truncation width of three. Zero
   // magnitudes, including -256, give zero. One times one stays exact. The
   // largest magnitudes give the top value of 65280.
   directed_row_type directed_rows [24] = '{
      '{ 9'sd0,    9'sd0,    1'b1, 16'd0     },
      '{ 9'sd0,    9'sd255,  1'b1, 16'd0     },
      '{-9'sd256,  9'sd7,    1'b1, 16'd0     },
      '{ 9'sd9,   -9'sd256,  1'b1, 16'd0     },
      '{-9'sd256, -9'sd256,  1'b1, 16'd0     },
      '{-9'sd256,  9'sd255,  1'b1, 16'd0     },
      '{ 9'sd1,    9'sd1,    1'b1, 16'd1     },
      '{-9'sd1,    9'sd1,    1'b1, 16'd1     },
      '{-9'sd1,   -9'sd1,    1'b1, 16'd1     },
      '{ 9'sd255,  9'sd255,  1'b1, 16'd65280 },
      '{-9'sd255,  9'sd255,  1'b1, 16'd65280 },
      '{-9'sd255, -9'sd255,  1'b1, 16'd65280 },
      '{ 9'sd128,  9'sd2,    1'b0, 16'd0     },
      '{-9'sd128, -9'sd128,  1'b0, 16'd0     },
      '{ 9'sd127,  9'sd127,  1'b0, 16'd0     },
      '{ 9'sd3,    9'sd5,    1'b0, 16'd0     },
      '{-9'sd7,    9'sd9,    1'b0, 16'd0     },
      '{ 9'sd100, -9'sd100,  1'b0, 16'd0     },
      '{ 9'sd64,   9'sd64,   1'b0, 16'd0     },
      '{ 9'sd85,   9'sd170,  1'b0, 16'd0     },
      '{-9'sd170, -9'sd85,   1'b0, 16'd0     },
      '{ 9'sd255,  9'sd1,    1'b0, 16'd0     },
      '{ 9'sd1,   -9'sd255,  1'b0, 16'd0     },
      '{-9'sd129,  9'sd254,  1'b0, 16'd0     }
   };

   // The random phases step through every truncation width. The first phase
   // uses zero, which turns truncation off, and the second uses seven, the
   // widest setting.
   logic [TRUNC_BITS-1:0] trunc_schedule [PHASE_COUNT] = '{
      3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd6, 3'd4, 3'd3
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   operand_type           req_operand_a   = '0;
   operand_type           req_operand_b   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   product_type           rsp_product_mag;
   logic                  csr_valid       = 1'b0;
   logic                  csr_ready;
   logic [TRUNC_BITS-1:0] csr_trunc_width = '0;

   // A hand-typed product travels alongside the operand word that it belongs
   // to. The monitor picks it up at the edge where the word is accepted.
   bit          pin_valid = 1'b0;
   product_type pin_value = '0;

   logic [TRUNC_BITS-1:0] trunc_setting = TRUNC_RESET;
   product_type           pending_products [$];
   product_type           oldest_product;
   int unsigned           fail_count  = 0;
   int unsigned           cycle_count = 0;

   int unsigned req_idle_pct = 7;
   int unsigned rsp_idle_pct = 49;
   bit          hold_pending = 1'b0;
   int unsigned hold_left    = 0;

   approx_log_multiplier_soa dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_product_mag (rsp_product_mag),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_trunc_width (csr_trunc_width)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // This function takes the magnitude of a two's complement operand and
   // folds it modulo 256. As a result, -256 comes out as zero.
   function automatic int unsigned folded_magnitude(input operand_type v);
      logic [IN_BITS-1:0] m;
      m = v[IN_BITS-1] ? -v : v;
      return int'(m) & ((1 << OPERAND_BITS) - 1);
   endfunction

   function automatic int unsigned leading_one(input int unsigned v);
      int unsigned pos;
      pos = 0;
      for (int i = 0; i < 32; i++)
         if (v[i])
            pos = i;
      return pos;
   endfunction

   // This is the Mitchell product with a set-one adder. Each operand is
   // split into a characteristic and a fraction. The truncated fractions are
   // added, with a carry when both dropped top bits are set. The low bits of
   // the sum are forced to one, and the antilog is taken as a shift.
   function automatic product_type mitchell_product(input operand_type a,
                                                    input operand_type b,
                                                    input logic [TRUNC_BITS-1:0] width);
      int unsigned      ma, mb, w, ones, keep, ka, kb, ya, yb, carry, sum, kl;
      int unsigned      fmask;
      longint unsigned  scaled;
      ma = folded_magnitude(a);
      mb = folded_magnitude(b);
      if (ma == 0 || mb == 0)
         return '0;
      fmask = (1 << FRAC_BITS) - 1;
      w = (width > FRAC_BITS) ? FRAC_BITS : width;
      ones = (1 << w) - 1;
      keep = fmask & ~ones;
      ka = leading_one(ma);
      kb = leading_one(mb);
      ya = (ma << (FRAC_BITS - ka)) & fmask;
      yb = (mb << (FRAC_BITS - kb)) & fmask;
      carry = 0;
      if (w > 0 && (((ya & yb) >> (w - 1)) & 1) != 0)
         carry = 1 << w;
      sum = ((ya & keep) + (yb & keep) + carry) | ones;
      kl = ka + kb + ((sum >> FRAC_BITS) & 1);
      sum = sum & fmask;
      scaled = ((longint'(1 << FRAC_BITS) + sum) << kl) >> FRAC_BITS;
      return scaled[PRODUCT_BITS-1:0];
   endfunction

   // Random operands are mostly full 9-bit values, which exercise every
   // bit. The rest are corner values, or small magnitudes and powers of two
   // with a random sign.
   function automatic operand_type random_operand();
      operand_type pick;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: pick = 9'sd0;
               1: pick = -9'sd256;
               2: pick = 9'sd255;
               3: pick = -9'sd255;
               4: pick = 9'sd1;
               default: pick = -9'sd1;
            endcase
         end
         1, 2: begin
            pick = operand_type'($urandom_range(1, 15));
            if ($urandom_range(0, 1) == 1)
               pick = -pick;
         end
         3: begin
            pick = operand_type'(1 << $urandom_range(0, OPERAND_BITS - 1));
            if ($urandom_range(0, 1) == 1)
               pick = -pick;
         end
         default: pick = operand_type'($urandom);
      endcase
      return pick;
   endfunction

   // The monitor samples at the rising edge. It checks a product word before
   // it records a new expectation, so an operand word accepted at the same
   // edge cannot hide a stray product word. The truncation width tracked
   // here changes only at the edge where a csr write is accepted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_products.size() == 0) begin
               $display("%0t: unexpected product word, actual %0d", $time, rsp_product_mag);
               fail_count++;
            end else begin
               oldest_product = pending_products.pop_front();
               if (rsp_product_mag !== oldest_product) begin
                  $display("%0t: product_mag mismatch, expected %0d, actual %0d",
                           $time, oldest_product, rsp_product_mag);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_products.push_back(pin_valid ? pin_value
               : mitchell_product(req_operand_a, req_operand_b, trunc_setting));
         if (csr_valid && csr_ready)
            trunc_setting = csr_trunc_width;
      end
   end

   // The run is cut off at a generous cycle limit in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d product words outstanding",
                  $time, pending_products.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver stalls at random at the current rate. A hold requested by
   // the stimulus keeps rsp_ready low for a long stretch. That stretch is
   // counted here, so the pipeline fills up while the sender keeps offering
   // words.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // This task offers one operand word and returns at the falling edge after
   // the word is accepted. Valid is left high, so that back-to-back words
   // never lower and raise it within the same time step. A random gap lowers
   // valid first.
   task automatic send_operands(input operand_type a, input operand_type b,
                                input bit has_product, input product_type product);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(negedge clock);
         while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid     <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      pin_valid     <= has_product;
      pin_value     <= product;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // This task stops offering words and waits until every product word has
   // come back. It then waits out the DRAIN_SLACK period to catch stray words.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_products.size() != 0)
         @(negedge clock);
      repeat (DRAIN_SLACK)
         @(negedge clock);
   endtask

   // The truncation width is written only while the pipeline is empty.
   task automatic write_trunc_width(input logic [TRUNC_BITS-1:0] width);
      csr_valid       <= 1'b1;
      csr_trunc_width <= width;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The directed rows run at the reset truncation width.
      foreach (directed_rows[i])
         send_operands(directed_rows[i].a, directed_rows[i].b,
                       directed_rows[i].has_product, directed_rows[i].product);
      drain_pipeline();

      // In the first three phases the sender rarely idles and the receiver
      // stalls about half the time. The next three phases swap the two
      // rates, and the last two run at full rate on both sides.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_trunc_width(trunc_schedule[phase]);
         if (phase < 3) begin
            req_idle_pct = 7;
            rsp_idle_pct = 49;
         end else if (phase < 6) begin
            req_idle_pct = 49;
            rsp_idle_pct = 7;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            // A long receiver hold backs up the pipeline into req_ready.
            if (phase == 1 && n == 100)
               hold_pending = 1'b1;
            // Partway through a phase, the sender pauses until the block is
            // empty.
            if (phase == 4 && n == 100)
               drain_pipeline();
            send_operands(random_operand(), random_operand(), 1'b0, '0);
         end
         drain_pipeline();
      end

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
